// File: rtl/iol_pkg.sv
// Shared types, constants and controller/datapath interface structs for the indexed ordered list.
package iol_pkg;

  // Default list size and value width.
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Width of the command field.
  localparam int CMD_W = 4;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 4'd0,
    CMD_INS_TAIL = 4'd1,
    CMD_INS_AT   = 4'd2,
    CMD_DEL_AT   = 4'd3,
    CMD_GET_AT   = 4'd4,
    CMD_LOCATE   = 4'd5,
    CMD_PRIOR    = 4'd6,
    CMD_NEXT     = 4'd7,
    CMD_CLEAR    = 4'd8
  } cmd_t;

  // Source of the memory read address.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_CUR,
    RD_IDX,
    RD_PREV,
    RD_NEXT
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    init_ins;
    logic    init_del;
    logic    init_scan;
    rd_sel_t rd_sel;
    logic    up;
    logic    shift_wr;
    logic    put_val;
    logic    dec_fill;
    logic    clr_fill;
    logic    cap_ov;
    logic    set_ok;
    logic    set_pos;
    logic    set_miss;
    logic    out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic ins_ok;
    logic acc_ok;
    logic rem_zero;
    logic pend;
    logic hit;
    logic at_head;
    logic has_next;
  } sts_t;

endpackage

// File: rtl/iol_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module iol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/iol_ctrl.sv
// Controller state machine that sequences each list transaction through the datapath.
module iol_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output iol_pkg::ctl_t ctl,
  input  iol_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_CAP,
    S_SHIFT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_del;

  assign in_stall = (state != S_IDLE);
  assign is_del   = (sts.cmd == iol_pkg::CMD_DEL_AT);

  // Next state and datapath commands.
  always_comb begin
    ctl        = '0;
    ctl.rd_sel = iol_pkg::RD_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.cmd)
          iol_pkg::CMD_INS_HEAD, iol_pkg::CMD_INS_TAIL, iol_pkg::CMD_INS_AT: begin
            if (sts.ins_ok) begin
              ctl.init_ins = 1'b1;
              state_next   = S_SHIFT;
            end else begin
              state_next = S_DONE;
            end
          end
          iol_pkg::CMD_DEL_AT, iol_pkg::CMD_GET_AT: begin
            if (sts.acc_ok) begin
              ctl.rd_sel = iol_pkg::RD_IDX;
              state_next = S_RD_CAP;
            end else begin
              state_next = S_DONE;
            end
          end
          iol_pkg::CMD_LOCATE, iol_pkg::CMD_PRIOR, iol_pkg::CMD_NEXT: begin
            ctl.init_scan = 1'b1;
            state_next    = S_SCAN;
          end
          iol_pkg::CMD_CLEAR: begin
            ctl.clr_fill = 1'b1;
            ctl.set_ok   = 1'b1;
            state_next   = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_RD_CAP: begin
        ctl.cap_ov = 1'b1;
        ctl.set_ok = 1'b1;
        if (is_del) begin
          ctl.init_del = 1'b1;
          state_next   = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        // Deletes move entries toward the head, inserts toward the tail.
        ctl.up       = is_del;
        ctl.shift_wr = 1'b1;
        if (!sts.rem_zero) begin
          ctl.rd_sel = iol_pkg::RD_CUR;
        end else if (!sts.pend) begin
          if (is_del) begin
            ctl.dec_fill = 1'b1;
          end else begin
            ctl.put_val = 1'b1;
            ctl.set_ok  = 1'b1;
          end
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        ctl.up = 1'b1;
        if (sts.hit) begin
          case (sts.cmd)
            iol_pkg::CMD_LOCATE: begin
              ctl.set_ok  = 1'b1;
              ctl.set_pos = 1'b1;
              state_next  = S_DONE;
            end
            iol_pkg::CMD_PRIOR: begin
              if (sts.at_head) begin
                state_next = S_DONE;
              end else begin
                ctl.rd_sel = iol_pkg::RD_PREV;
                state_next = S_RD_CAP;
              end
            end
            iol_pkg::CMD_NEXT: begin
              if (sts.has_next) begin
                ctl.rd_sel = iol_pkg::RD_NEXT;
                state_next = S_RD_CAP;
              end else begin
                state_next = S_DONE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end else if (!sts.rem_zero) begin
          ctl.rd_sel = iol_pkg::RD_CUR;
        end else if (!sts.pend) begin
          // No entry matched.
          if (sts.cmd == iol_pkg::CMD_LOCATE) begin
            ctl.set_miss = 1'b1;
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/iol_datapath.sv
// Datapath of the indexed ordered list: value memory, fill count, walk pointers and result registers.
module iol_datapath #(
  parameter int CAPACITY   = iol_pkg::CAPACITY,
  parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  iol_pkg::ctl_t                ctl,
  output iol_pkg::sts_t                sts,
  input  logic [iol_pkg::CMD_W-1:0]    cmd,
  input  logic [CW-1:0]                index,
  input  logic signed [DATA_WIDTH-1:0] value,
  output logic                         ok,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic signed [CW-1:0]         position,
  output logic [CW-1:0]                count_now,
  output logic                         is_empty
);

  iol_pkg::cmd_t          cmd_q;
  logic [CW-1:0]          idx_q;
  logic [DATA_WIDTH-1:0]  val_q;
  logic [CW-1:0]          fill;
  logic [CW-1:0]          rem;
  logic [AW-1:0]          cur;
  logic [AW-1:0]          raddr_q;
  logic [AW-1:0]          p_q;
  logic                   pend;
  logic                   ok_q;
  logic [DATA_WIDTH-1:0]  ov_q;
  logic [CW-1:0]          pos_q;
  logic [CW-1:0]          ins_pos;
  logic                   full;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [DATA_WIDTH-1:0]  rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [DATA_WIDTH-1:0]  wr_data;

  // Insert position for the three insert commands.
  always_comb begin
    case (cmd_q)
      iol_pkg::CMD_INS_HEAD: ins_pos = '0;
      iol_pkg::CMD_INS_TAIL: ins_pos = fill;
      default:               ins_pos = idx_q;
    endcase
  end

  assign full = (fill == CW'(CAPACITY));

  // Read address selection.
  always_comb begin
    case (ctl.rd_sel)
      iol_pkg::RD_CUR:  rd_addr = cur;
      iol_pkg::RD_IDX:  rd_addr = AW'(idx_q);
      iol_pkg::RD_PREV: rd_addr = raddr_q - AW'(1);
      iol_pkg::RD_NEXT: rd_addr = raddr_q + AW'(1);
      default:          rd_addr = '0;
    endcase
  end

  assign rd_en = (ctl.rd_sel != iol_pkg::RD_NONE);

  // Shift writes land one place away from the entry read the cycle before.
  assign wr_en   = (ctl.shift_wr && pend) || ctl.put_val;
  assign wr_addr = ctl.put_val ? p_q : (ctl.up ? raddr_q - AW'(1) : raddr_q + AW'(1));
  assign wr_data = ctl.put_val ? val_q : rd_data;

  iol_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status toward the controller.
  always_comb begin
    sts          = '0;
    sts.cmd      = cmd_q;
    sts.ins_ok   = !full && (ins_pos <= fill);
    sts.acc_ok   = (idx_q < fill);
    sts.rem_zero = (rem == '0);
    sts.pend     = pend;
    sts.hit      = pend && (rd_data == val_q);
    sts.at_head  = (raddr_q == '0);
    sts.has_next = ((CW + 1)'(raddr_q) + (CW + 1)'(1)) < (CW + 1)'(fill);
  end

  // Fill count and read-pending flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pend <= 1'b0;
    end else begin
      pend <= (ctl.rd_sel == iol_pkg::RD_CUR);
      if (ctl.clr_fill) begin
        fill <= '0;
      end else if (ctl.put_val) begin
        fill <= fill + CW'(1);
      end else if (ctl.dec_fill) begin
        fill <= fill - CW'(1);
      end
    end
  end

  // Transaction, walk and result registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= iol_pkg::cmd_t'(cmd);
      idx_q <= index;
      val_q <= value;
      ok_q  <= 1'b0;
      ov_q  <= '0;
      pos_q <= '0;
    end
    if (ctl.init_ins) begin
      rem <= fill - ins_pos;
      cur <= AW'(fill - CW'(1));
      p_q <= AW'(ins_pos);
    end
    if (ctl.init_del) begin
      rem <= fill - idx_q - CW'(1);
      cur <= AW'(idx_q + CW'(1));
    end
    if (ctl.init_scan) begin
      rem <= fill;
      cur <= '0;
    end
    if (ctl.rd_sel == iol_pkg::RD_CUR) begin
      cur <= ctl.up ? cur + AW'(1) : cur - AW'(1);
      rem <= rem - CW'(1);
    end
    if (rd_en) begin
      raddr_q <= rd_addr;
    end
    if (ctl.cap_ov) begin
      ov_q <= rd_data;
    end
    if (ctl.set_ok) begin
      ok_q <= 1'b1;
    end
    if (ctl.set_pos) begin
      pos_q <= CW'(raddr_q);
    end
    if (ctl.set_miss) begin
      pos_q <= '1;
    end
    if (ctl.out_load) begin
      ok        <= ok_q;
      out_value <= ov_q;
      position  <= pos_q;
      count_now <= fill;
      is_empty  <= (fill == '0);
    end
  end

endmodule

// File: rtl/indexed_ordered_list_core.sv
// Top level of the indexed ordered list: controller, datapath and value memory.
// Holds an ordered list of up to CAPACITY signed values in a single-port-per-side RAM and
// executes one command per transaction, returning one result per command. Inserts and
// deletes move the entries behind the affected position one memory access per cycle, and
// locate, prior and next compare stored entries from the head one per cycle; that walk
// through the value memory sets the rate. A new command is taken as soon as the previous
// one is finished internally, even while its result still waits in the output register.
module indexed_ordered_list_core #(
  parameter int CAPACITY   = iol_pkg::CAPACITY,
  parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [iol_pkg::CMD_W-1:0]    cmd,
  input  logic [CW-1:0]                index,
  input  logic signed [DATA_WIDTH-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic signed [CW-1:0]         position,
  output logic [CW-1:0]                count_now,
  output logic                         is_empty
);

  iol_pkg::ctl_t ctl;
  iol_pkg::sts_t sts;

  // Sequencer.
  iol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  // Storage and result datapath.
  iol_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cmd       (cmd),
    .index     (index),
    .value     (value),
    .ok        (ok),
    .out_value (out_value),
    .position  (position),
    .count_now (count_now),
    .is_empty  (is_empty)
  );

endmodule

// File: rtl/iol_checker.sv
// Port-level assertions for the indexed ordered list, bound to the top level.
module iol_checker #(
  parameter int CAPACITY   = iol_pkg::CAPACITY,
  parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [iol_pkg::CMD_W-1:0]    cmd,
  input logic [CW-1:0]                index,
  input logic signed [DATA_WIDTH-1:0] value,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         ok,
  input logic signed [DATA_WIDTH-1:0] out_value,
  input logic signed [CW-1:0]         position,
  input logic [CW-1:0]                count_now,
  input logic                         is_empty
);

  // A stalled command transaction stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(cmd) && $stable(index) && $stable(value))
    else $error("stalled command changed");

  // A stalled result transaction stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ok) && $stable(out_value)
      && $stable(position) && $stable(count_now) && $stable(is_empty))
    else $error("stalled result changed");

  // The empty flag agrees with the reported length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count_now == '0)))
    else $error("empty flag disagrees with length");

  // The list never reports more entries than it can hold.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count_now <= CW'(CAPACITY)))
    else $error("length beyond capacity");

  // A failed command returns no value, and a position only as the miss marker.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> (out_value == '0) && ((position == '0) || (position == '1)))
    else $error("failed command returned data");

endmodule

bind indexed_ordered_list_core iol_checker #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_iol_checker (.*);
